// ===== design/cvn_pkg.sv =====
// Package for complex_vector_normalize: sizes, widths and shared command/status types.
// No dependencies.
package cvn_pkg;
    localparam int MAX_LEN   = 64;
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int PART_W    = 16;
    localparam int SUM_W     = 31 + $clog2(MAX_LEN + 1);
    localparam int ROOT_W    = (SUM_W + 1) / 2;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int Q_SHIFT   = 14;
    localparam int DIV_N_W   = PART_W + Q_SHIFT;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam logic [PART_W-1:0] Q_ONE = PART_W'(1 << Q_SHIFT);

    typedef struct packed {
        logic load;
        logic sum_clear;
        logic root_start;
        logic root_step;
        logic div_start_re;
        logic div_start_im;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sum_zero;
    } t_stat;
endpackage

// ===== design/cvn_if.sv =====
// Valid/ready channel interfaces for complex_vector_normalize.
// Depends on cvn_pkg.
interface cvn_in_if import cvn_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [PART_W-1:0] elem_real;
    logic signed [PART_W-1:0] elem_imag;
    logic last_element;
    modport source (output valid, elem_real, elem_imag, last_element, input ready);
    modport sink (input valid, elem_real, elem_imag, last_element, output ready);
endinterface

interface cvn_out_if import cvn_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [PART_W-1:0] norm_real;
    logic signed [PART_W-1:0] norm_imag;
    logic last_out;
    logic error_flag;
    modport source (output valid, norm_real, norm_imag, last_out, error_flag, input ready);
    modport sink (input valid, norm_real, norm_imag, last_out, error_flag, output ready);
endinterface

// ===== design/complex_vector_normalize.sv =====
// Top level of complex_vector_normalize: controller, datapath and assertions.
// Depends on cvn_pkg, cvn_if, cvn_ctrl and cvn_datapath.
//
// Input channel: one complex element per transaction, last_element closes the vector.
// Up to MAX_LEN elements are kept, further ones are dropped and mark every
// result of the vector with error_flag. After the last element the sum
// settles in S_SUM, then the bit-serial square root runs in S_ROOT.
// Each result is then read from memory into a register in S_RD and divided
// by the shared restoring divider that takes one quotient bit per cycle,
// real part in S_DRE then imaginary part in S_DIM, before it is presented
// in S_OUT; a further result is started only once this one's output
// transaction completes.
// Results stay in the output register while the receiver stalls; nothing
// advances until the transaction completes. Input is not taken while a vector
// is being emitted.
// A zero vector yields zero parts with error_flag set.
// Reset returns the controller to loading with empty count, sum and flags; the
// element memory is not cleared.
module complex_vector_normalize import cvn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    cvn_in_if.sink    i_in,
    cvn_out_if.source o_out
);
    t_cmd w_cmd;
    t_stat w_stat;
    logic [IDX_W-1:0] w_wr_idx, w_rd_idx;

    cvn_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .i_in_last(i_in.last_element),
        .i_out_ready(o_out.ready), .i_stat(w_stat),
        .o_in_ready(i_in.ready), .o_out_valid(o_out.valid),
        .o_last_out(o_out.last_out), .o_error_flag(o_out.error_flag),
        .o_cmd(w_cmd), .o_wr_idx(w_wr_idx), .o_rd_idx(w_rd_idx)
    );

    cvn_datapath u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd),
        .i_re(i_in.elem_real), .i_im(i_in.elem_imag),
        .i_wr_idx(w_wr_idx), .i_rd_idx(w_rd_idx), .o_stat(w_stat),
        .o_norm_real(o_out.norm_real), .o_norm_imag(o_out.norm_imag)
    );

    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready) else $error("input open during emit");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.norm_real))
        else $error("result lost on stall");
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && o_out.last_out |=> i_in.ready)
        else $error("input not reopened after vector");
endmodule

// ===== design/cvn_datapath.sv =====
// Datapath: element memory, square sum, bit-serial square root and divider.
// Depends on cvn_pkg.
module cvn_datapath import cvn_pkg::*; (
    input  logic i_clk,
    input  t_cmd i_cmd,
    input  logic signed [PART_W-1:0] i_re,
    input  logic signed [PART_W-1:0] i_im,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_stat o_stat,
    output logic signed [PART_W-1:0] o_norm_real,
    output logic signed [PART_W-1:0] o_norm_imag
);
    logic [2*PART_W-1:0] r_mem [MAX_LEN];
    logic [2*PART_W-1:0] r_rd;
    logic [SUM_W-1:0] r_sum;
    logic [2*PART_W-1:0] r_sq_re, r_sq_im;
    logic r_sq_valid;
    logic [SUM_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [2*ROOT_W-1:0] r_rad;
    logic [DIV_N_W-1:0] r_num;
    logic [ROOT_W:0] r_drem;
    logic r_neg;
    logic signed [PART_W-1:0] r_q_re;

    logic [ROOT_W:0] n_drem;
    logic [ROOT_W+1:0] n_dsub;
    logic [PART_W-1:0] w_part;
    logic [PART_W-1:0] w_abs;
    logic [PART_W-1:0] w_q;
    logic signed [PART_W-1:0] w_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[i_wr_idx] <= {i_im, i_re};
        end
        r_rd <= r_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        r_sq_valid <= i_cmd.load;
        r_sq_re <= (2*PART_W)'(i_re * i_re);
        r_sq_im <= (2*PART_W)'(i_im * i_im);
        if (i_cmd.sum_clear) begin
            r_sum <= '0;
        end else if (r_sq_valid) begin
            r_sum <= r_sum + SUM_W'(r_sq_re) + SUM_W'(r_sq_im);
        end
    end

    assign o_stat.sum_zero = (r_sum == '0);

    // restoring square root, one result bit per step
    always_ff @(posedge i_clk) begin
        logic [2*ROOT_W+1:0] acc;
        logic [2*ROOT_W+1:0] t;
        if (i_cmd.root_start) begin
            r_rem  <= (SUM_W+2)'(r_sum) << (2*ROOT_W + 2 - SUM_W);
            r_rad  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            acc = {r_rad, r_rem[SUM_W+1 -: 2]};
            t   = {r_root, 2'b01};
            if (acc >= t) begin
                r_rad  <= (2*ROOT_W)'(acc - t);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rad  <= (2*ROOT_W)'(acc);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
            r_rem <= r_rem << 2;
        end
    end

    assign w_part = i_cmd.div_start_re ? r_rd[PART_W-1:0] : r_rd[2*PART_W-1:PART_W];
    assign w_abs  = w_part[PART_W-1] ? PART_W'(-w_part) : w_part;
    assign n_dsub = {r_drem, r_num[DIV_N_W-1]} - (ROOT_W+2)'(r_root);
    assign n_drem = n_dsub[ROOT_W+1] ? (ROOT_W+1)'({r_drem, r_num[DIV_N_W-1]})
                                     : (ROOT_W+1)'(n_dsub);
    assign w_q   = (r_num > DIV_N_W'(Q_ONE)) ? Q_ONE : PART_W'(r_num);
    assign w_res = (r_root == '0) ? '0 : (r_neg ? PART_W'(-w_q) : w_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start_re || i_cmd.div_start_im) begin
            r_num  <= DIV_N_W'(w_abs) << Q_SHIFT;
            r_neg  <= w_part[PART_W-1];
            r_drem <= '0;
        end else if (i_cmd.div_step) begin
            r_drem <= n_drem;
            r_num  <= {r_num[DIV_N_W-2:0], ~n_dsub[ROOT_W+1]};
        end
        if (i_cmd.div_start_im) begin
            r_q_re <= w_res;
        end
        if (i_cmd.out_load) begin
            o_norm_real <= r_q_re;
            o_norm_imag <= w_res;
        end
    end
endmodule

// ===== design/cvn_ctrl.sv =====
// Controller: load, root and emit sequencing with the output handshake.
// Depends on cvn_pkg.
module cvn_ctrl import cvn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    input  logic i_out_ready,
    input  t_stat i_stat,
    output logic o_in_ready,
    output logic o_out_valid,
    output logic o_last_out,
    output logic o_error_flag,
    output t_cmd o_cmd,
    output logic [IDX_W-1:0] o_wr_idx,
    output logic [IDX_W-1:0] o_rd_idx
);
    typedef enum logic [2:0] {S_LOAD, S_SUM, S_ROOT, S_RD, S_DRE, S_DIM, S_OUT} t_state;
    t_state r_state;
    logic [CNT_W-1:0] r_count, r_idx;
    logic [STEP_W-1:0] r_step;
    logic r_over;
    logic w_acc;

    assign o_in_ready = (r_state == S_LOAD);
    assign w_acc = i_in_valid && o_in_ready;
    assign o_wr_idx = r_count[IDX_W-1:0];
    assign o_rd_idx = r_idx[IDX_W-1:0];

    always_comb begin
        o_cmd = '0;
        o_cmd.load = w_acc && (r_count < CNT_W'(MAX_LEN));
        o_cmd.sum_clear = !i_rst_n
                       || ((r_state == S_OUT) && o_out_valid && i_out_ready && o_last_out);
        o_cmd.root_start = (r_state == S_SUM);
        o_cmd.root_step = (r_state == S_ROOT);
        o_cmd.div_start_re = (r_state == S_RD) && (r_step == STEP_W'(1));
        o_cmd.div_step = (r_state == S_DRE) || (r_state == S_DIM);
        o_cmd.div_start_im = (r_state == S_DRE) && (r_step == STEP_W'(DIV_STEPS));
        o_cmd.out_load = (r_state == S_DIM) && (r_step == STEP_W'(DIV_STEPS));
        if (o_cmd.div_start_im) o_cmd.div_step = 1'b0;
        if (o_cmd.out_load) o_cmd.div_step = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_idx <= '0;
            r_step <= '0;
            r_over <= 1'b0;
            o_out_valid <= 1'b0;
            o_last_out <= 1'b0;
            o_error_flag <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        if (o_cmd.load) r_count <= r_count + 1'b1;
                        else r_over <= 1'b1;
                        if (i_in_last) begin
                            r_state <= S_SUM;
                            r_step <= '0;
                        end
                    end
                end
                S_SUM: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(1)) begin
                        r_state <= S_ROOT;
                        r_step <= '0;
                    end
                end
                S_ROOT: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(ROOT_STEPS - 1)) begin
                        r_state <= S_RD;
                        r_step <= '0;
                        r_idx <= '0;
                    end
                end
                S_RD: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(1)) begin
                        r_state <= S_DRE;
                        r_step <= '0;
                    end
                end
                S_DRE: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_STEPS)) begin
                        r_state <= S_DIM;
                        r_step <= '0;
                    end
                end
                S_DIM: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_STEPS)) begin
                        r_state <= S_OUT;
                        o_out_valid <= 1'b1;
                        o_last_out <= (r_idx + 1'b1 == r_count);
                        o_error_flag <= r_over || i_stat.sum_zero;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        r_step <= '0;
                        if (o_last_out) begin
                            r_state <= S_LOAD;
                            r_count <= '0;
                            r_over <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule
